// ===== design/fpamd_pkg.sv =====
// ---------------------------------------------------------------------------
// fpamd_pkg
// Shared constants and operation codes of the fixed-point arithmetic unit.
// ---------------------------------------------------------------------------
package fpamd_pkg;

	localparam int OPERAND_W_DEF  = 32;
	localparam int MAX_FRAC_DEF   = 30;
	localparam int FRAC_W         = 5;
	localparam int RES_W          = 64;
	localparam int QUEUE_DEPTH    = 4;
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MUL = 2'd1;
	localparam logic [1:0] MODE_DIV = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_MUL = 2'd1;
	localparam logic [1:0] OP_DIV = 2'd2;
	localparam logic [1:0] OP_BAD = 2'd3;

endpackage

// ===== design/fpamd_queue.sv =====
// ---------------------------------------------------------------------------
// fpamd_queue
// Short first-in first-out buffer between the front and back parts.
// ---------------------------------------------------------------------------
module fpamd_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);
	import fpamd_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [DW-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count overrun");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !(pop && !empty)) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

// ===== design/fpamd_front.sv =====
// ---------------------------------------------------------------------------
// fpamd_front
// Accepts items, classifies the operation and prepares the operand word.
// ---------------------------------------------------------------------------
module fpamd_front #(
	parameter int OPERAND_WIDTH = fpamd_pkg::OPERAND_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [OPERAND_WIDTH-1:0]      left_operand,
	input  logic [OPERAND_WIDTH-1:0]      right_operand,
	input  logic [fpamd_pkg::FRAC_W-1:0]  eff_frac,
	output logic                          push,
	output logic [2+1+fpamd_pkg::RES_W+OPERAND_WIDTH-1:0] entry,
	input  logic                          full
);
	import fpamd_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic         vld_s1;
	logic [1:0]   mode_s1;
	logic [W-1:0] l_s1, r_s1;

	logic [W-1:0]     lmag, rmag;
	logic [2*W-1:0]   prod;
	logic [RES_W-1:0] acc;
	logic [1:0]       op;
	logic             neg;

	assign in_ready = !vld_s1 || !full;
	assign push     = vld_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			l_s1    <= left_operand;
			r_s1    <= right_operand;
		end
	end

	assign lmag = l_s1[W-1] ? W'(-l_s1) : l_s1;
	assign rmag = r_s1[W-1] ? W'(-r_s1) : r_s1;
	assign prod = (2*W)'(lmag) * (2*W)'(rmag);

	always_comb begin
		op  = OP_BAD;
		neg = l_s1[W-1] ^ r_s1[W-1];
		acc = '0;
		unique case (mode_s1)
			MODE_ADD: begin
				op  = OP_ADD;
				neg = 1'b0;
				acc = RES_W'($signed(l_s1)) + RES_W'($signed(r_s1));
			end
			MODE_MUL: begin
				op  = OP_MUL;
				acc = RES_W'(prod);
			end
			MODE_DIV: begin
				if (r_s1 != '0) begin
					op  = OP_DIV;
					acc = RES_W'(lmag) << eff_frac;
				end
			end
			default: begin
				op = OP_BAD;
			end
		endcase
	end

	assign entry = {op, neg, acc, rmag};

endmodule

// ===== design/fpamd_back.sv =====
// ---------------------------------------------------------------------------
// fpamd_back
// Bit-per-stage restoring divider pipeline with sign and scale fix-up.
// ---------------------------------------------------------------------------
module fpamd_back #(
	parameter int OPERAND_WIDTH = fpamd_pkg::OPERAND_W_DEF,
	parameter int MAX_FRAC_BITS = fpamd_pkg::MAX_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2+1+fpamd_pkg::RES_W+OPERAND_WIDTH-1:0] entry,
	input  logic                          empty,
	output logic                          pop,
	input  logic [fpamd_pkg::FRAC_W-1:0]  eff_frac,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fpamd_pkg::RES_W-1:0]   result_value,
	output logic                          ok
);
	import fpamd_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int QW = OPERAND_WIDTH + MAX_FRAC_BITS;

	typedef struct packed {
		logic             vld;
		logic [1:0]       op;
		logic             neg;
		logic [RES_W-1:0] acc;
		logic [W-1:0]     dsr;
		logic [W:0]       rem;
	} stage_t;

	stage_t            div_s [QW];
	stage_t            head;
	logic              adv;
	logic              out_valid_q, ok_q;
	logic [RES_W-1:0]  result_q;
	logic [RES_W-1:0]  mag;
	stage_t            last;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;

	always_comb begin
		head     = '0;
		head.vld = !empty;
		{head.op, head.neg, head.acc, head.dsr} = entry;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		stage_t     src;
		logic [W:0] r2;
		logic       ge;

		if (k == 0) begin : g_first
			assign src = head;
		end else begin : g_next
			assign src = div_s[k-1];
		end

		assign r2 = {src.rem[W-1:0], src.acc[QW-1]};
		assign ge = (r2 >= {1'b0, src.dsr});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k] <= '0;
			end else if (adv) begin
				div_s[k].vld <= src.vld;
				div_s[k].op  <= src.op;
				div_s[k].neg <= src.neg;
				div_s[k].dsr <= src.dsr;
				if (src.op == OP_DIV) begin
					div_s[k].rem <= ge ? (r2 - {1'b0, src.dsr}) : r2;
					div_s[k].acc <= {src.acc[RES_W-1:QW], src.acc[QW-2:0], ge};
				end else begin
					div_s[k].rem <= src.rem;
					div_s[k].acc <= src.acc;
				end
			end
		end
	end

	assign last = div_s[QW-1];
	assign mag  = (last.op == OP_MUL) ? (last.acc >> eff_frac) : last.acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q <= (last.op != OP_BAD);
			unique case (last.op)
				OP_ADD:  result_q <= last.acc;
				OP_MUL,
				OP_DIV:  result_q <= last.neg ? RES_W'(-mag) : mag;
				default: result_q <= '0;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign ok           = ok_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (result_q == '0)) else $error("failed item not zero");

	a_last_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last.vld) |=> out_valid_q) else $error("item dropped at output");

endmodule

// ===== design/fixed_point_add_mul_div_unit.sv =====
// ---------------------------------------------------------------------------
// fixed_point_add_mul_div_unit
// Signed fixed-point add, multiply and divide on raw integers.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries mode, left_operand, right_operand;
// output channel out_valid/out_ready carries result_value and ok.
// cfg_wr_en/cfg_wr_data set frac_bits (values above MAX_FRAC_BITS act as the
// cap); write it only while the unit is empty.
// Every item runs the same path: an input register, a 4-entry queue, one
// restoring-division stage per quotient bit (OPERAND_WIDTH + MAX_FRAC_BITS
// stages, 62 by default) and an output register. One item is taken per
// cycle while in_ready is high, in order.
// Divide by zero and mode 3 give result 0 with ok low.
// Reset empties the pipeline and queue and sets frac_bits to 16.
// A stall on out_ready holds the divider pipeline; the queue and input
// register keep taking items until they fill, then in_ready drops.
// ---------------------------------------------------------------------------
module fixed_point_add_mul_div_unit #(
	parameter int OPERAND_WIDTH = fpamd_pkg::OPERAND_W_DEF,
	parameter int MAX_FRAC_BITS = fpamd_pkg::MAX_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fpamd_pkg::FRAC_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [OPERAND_WIDTH-1:0]     left_operand,
	input  logic [OPERAND_WIDTH-1:0]     right_operand,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fpamd_pkg::RES_W-1:0]  result_value,
	output logic                         ok
);
	import fpamd_pkg::*;

	localparam int DW = 2 + 1 + RES_W + OPERAND_WIDTH;

	logic [FRAC_W-1:0] frac_bits_q, eff_frac;
	logic              push, full, pop, empty;
	logic [DW-1:0]     wentry, rentry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q <= FRAC_RESET;
		end else if (cfg_wr_en) begin
			frac_bits_q <= cfg_wr_data;
		end
	end

	assign eff_frac = (frac_bits_q > FRAC_W'(MAX_FRAC_BITS)) ?
		FRAC_W'(MAX_FRAC_BITS) : frac_bits_q;

	fpamd_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .left_operand, .right_operand,
		.eff_frac, .push, .entry(wentry), .full
	);

	fpamd_queue #(.DW(DW)) u_queue (
		.clk, .arst_n, .push, .wdata(wentry), .full, .pop, .rdata(rentry), .empty
	);

	fpamd_back #(.OPERAND_WIDTH(OPERAND_WIDTH), .MAX_FRAC_BITS(MAX_FRAC_BITS)) u_back (
		.clk, .arst_n, .entry(rentry), .empty, .pop, .eff_frac,
		.out_valid, .out_ready, .result_value, .ok
	);

endmodule

// ===== tb/sv/fixed_point_add_mul_div_unit_chk.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_point_add_mul_div_unit_chk
// Watches both channels of the fixed-point unit, computes the expected
// result of every accepted item and compares it with the results in order.
// ---------------------------------------------------------------------------
module fixed_point_add_mul_div_unit_chk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fpamd_pkg::FRAC_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [31:0]                  left_operand,
	input  logic [31:0]                  right_operand,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [fpamd_pkg::RES_W-1:0]  result_value,
	input  logic                         ok,
	output int                           errors,
	output int                           pending
);
	import fpamd_pkg::*;

	typedef struct packed {
		logic [63:0] value;
		logic        ok;
	} qres_t;

	qres_t            expected_results[$];
	logic [FRAC_W-1:0] frac_bits_q;

	assign pending = expected_results.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic qres_t q_compute(input logic [1:0] op, input logic [31:0] a,
		input logic [31:0] b, input logic [FRAC_W-1:0] fb);
		longint l, r, sc, res;
		int unsigned f;
		qres_t q;
		l = longint'($signed(a));
		r = longint'($signed(b));
		f = (fb > MAX_FRAC_DEF) ? MAX_FRAC_DEF : fb;
		sc = longint'(1) << f;
		res = 0;
		q.ok = 1'b0;
		case (op)
			OP_ADD: begin
				res = l + r;
				q.ok = 1'b1;
			end
			OP_MUL: begin
				res = (l * r) / sc;
				q.ok = 1'b1;
			end
			OP_DIV: begin
				if (r != 0) begin
					res = (l * sc) / r;
					q.ok = 1'b1;
				end
			end
			default: ;
		endcase
		q.value = res;
		return q;
	endfunction

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		qres_t e;
		if (!arst_n) begin
			frac_bits_q <= FRAC_RESET;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(q_compute(mode, left_operand, right_operand,
					frac_bits_q));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("result with no item outstanding");
				end else begin
					e = expected_results.pop_front();
					if (result_value !== e.value)
						report($sformatf("result_value %0d, expected %0d",
							$signed(result_value), $signed(e.value)));
					if (ok !== e.ok)
						report($sformatf("ok %b, expected %b", ok, e.ok));
				end
			end
			if (cfg_wr_en)
				frac_bits_q <= cfg_wr_data;
		end
	end
endmodule

// ===== tb/sv/fixed_point_add_mul_div_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_point_add_mul_div_unit_tb
// Directed and random add, multiply, divide and invalid-mode items over several
// fraction widths, with random idling on both channels; the checker scores results.
// ---------------------------------------------------------------------------
module fixed_point_add_mul_div_unit_tb;
	import fpamd_pkg::*;

	logic              clk, arst_n;
	logic              cfg_wr_en;
	logic [FRAC_W-1:0] cfg_wr_data;
	logic              in_valid, in_ready, out_valid, out_ready, ok;
	logic [1:0]        mode;
	logic [31:0]       left_operand, right_operand;
	logic [RES_W-1:0]  result_value;
	int                errors, pending;
	int                cycles;
	bit                calm;

	fixed_point_add_mul_div_unit dut (.*);
	fixed_point_add_mul_div_unit_chk chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("fixed_point_add_mul_div_unit test failed");
				$finish;
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 9);

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(64)) - 32);
			3: return 32'($urandom_range(32'hffff)) << $urandom_range(16);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [31:0] a,
		input logic [31:0] b);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		left_operand <= a;
		right_operand <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_frac(input logic [FRAC_W-1:0] fb);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= fb;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	logic [FRAC_W-1:0] settings[6] = '{5'd16, 5'd0, 5'd30, 5'd31, 5'd1, 5'd8};

	initial begin
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		in_valid = 0;
		mode = OP_ADD;
		left_operand = '0;
		right_operand = '0;
		out_ready = 0;
		calm = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes at the reset width
		send_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_MUL, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
		send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_item(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
		send_item(OP_DIV, 32'h1234_5678, 32'h0000_0000);
		send_item(OP_DIV, 32'hffff_fff9, 32'h0000_0002);
		send_item(OP_BAD, 32'h7fff_ffff, 32'h0000_0003);
		send_item(OP_BAD, 32'h0, 32'h0);
		drain();

		for (int s = 0; s < 6; s++) begin
			set_frac(settings[s]);
			send_item(OP_MUL, 32'h8000_0000, 32'h7fff_ffff);
			send_item(OP_DIV, 32'h8000_0000, 32'h0000_0001);
			send_item(OP_DIV, 32'h0000_0005, 32'h0000_0000);
			calm = (s == 2);
			for (int i = 0; i < 230; i++) begin
				logic [1:0] m;
				m = ($urandom_range(19) == 0) ? OP_BAD : 2'($urandom_range(2));
				send_item(m, pick_operand(), pick_operand());
				if (s == 4 && i == 100) drain();
			end
			calm = 0;
			drain();
		end

		if (errors == 0)
			$display("fixed_point_add_mul_div_unit test passed");
		else
			$display("fixed_point_add_mul_div_unit test failed");
		$finish;
	end
endmodule
